[sv/mctp_reassembly_context_tracker_core_macros.svh]
// Assertion macros for the MCTP reassembly context tracker.
`ifndef MCTP_REASSEMBLY_CONTEXT_TRACKER_CORE_MACROS_SVH
`define MCTP_REASSEMBLY_CONTEXT_TRACKER_CORE_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define MRCT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies another in the next cycle.
`define MRCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/mrct_pkg.sv]
// Types and constants shared by the MCTP reassembly context tracker.
package mrct_pkg;

	localparam int KEY_W  = 12;
	localparam int LEN_W  = 11;
	localparam int CNT_W  = 8;
	localparam int SEQ_W  = 2;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

	typedef enum logic [1:0] {
		REG_OWN_EID  = 2'd0,
		REG_HDR_VER  = 2'd1,
		REG_FULL_LEN = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		V_IGNORED   = 4'd0,
		V_SINGLE    = 4'd1,
		V_STARTED   = 4'd2,
		V_APPENDED  = 4'd3,
		V_COMPLETED = 4'd4,
		V_BADLEN    = 4'd5,
		V_BADSEQ    = 4'd6,
		V_ORPHAN    = 4'd7,
		V_FULL      = 4'd8
	} verdict_t;

	typedef enum logic [1:0] {
		K_IGNORE = 2'd0,
		K_SINGLE = 2'd1,
		K_LOOKUP = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t            kind;
		logic [KEY_W-1:0] key;
		logic             som;
		logic             eom;
		logic             full_len;
		logic [SEQ_W-1:0] seq;
	} cmd_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [SEQ_W-1:0] seq;
		logic [CNT_W-1:0] count;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_SCAN   = 2'd1,
		ST_LAST   = 2'd2,
		ST_DECIDE = 2'd3
	} st_t;

endpackage

[sv/mctp_reassembly_context_tracker_core.sv]
// Top level of the MCTP reassembly context tracker.
//
//   channel   direction  handshake             payload
//   config    in         psel/penable/pready   paddr, pwdata, prdata
//   packet    in         in_valid/in_stall     version .. packet_len
//   verdict   out        out_valid/out_stall   verdict, slot, packet_count, deliver
//
// Ignored and start-and-end packets are answered straight from the idle state once queued.
// Other packets scan the context table RAM one entry a cycle through its single
// read port, then a decide state, held while out_stall blocks it, decides and writes.
// Reset clears the entry valid bits and loads the register defaults; no clearing pass.
// out_stall holds the result register and the back end's decide and output steps;
// the two-entry queue keeps the front accepting packets meanwhile until it fills.
`include "mctp_reassembly_context_tracker_core_macros.svh"

module mctp_reassembly_context_tracker_core #(
	parameter int CONTEXTS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mrct_pkg::ADDR_W-1:0] paddr,
	input  logic [mrct_pkg::DATA_W-1:0] pwdata,
	output logic [mrct_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [3:0]                  version,
	input  logic [7:0]                  dest_eid,
	input  logic [7:0]                  source_eid,
	input  logic [2:0]                  msg_tag,
	input  logic                        msg_owner,
	input  logic                        start_of_msg,
	input  logic                        end_of_msg,
	input  logic [1:0]                  seq_num,
	input  logic [10:0]                 packet_len,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [3:0]                  verdict,
	output logic [2:0]                  slot,
	output logic [7:0]                  packet_count,
	output logic                        deliver
);

	logic           q_full;
	logic           push;
	mrct_pkg::cmd_t push_cmd;
	logic           pop;
	logic           q_valid;
	mrct_pkg::cmd_t q_cmd;

	mrct_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.version     (version),
		.dest_eid    (dest_eid),
		.source_eid  (source_eid),
		.msg_tag     (msg_tag),
		.msg_owner   (msg_owner),
		.start_of_msg(start_of_msg),
		.end_of_msg  (end_of_msg),
		.seq_num     (seq_num),
		.packet_len  (packet_len),
		.q_full      (q_full),
		.push        (push),
		.cmd         (push_cmd)
	);

	mrct_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.full    (q_full),
		.pop     (pop),
		.q_valid (q_valid),
		.q_cmd   (q_cmd)
	);

	mrct_back #(
		.CONTEXTS(CONTEXTS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_cmd       (q_cmd),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.verdict     (verdict),
		.slot        (slot),
		.packet_count(packet_count),
		.deliver     (deliver)
	);

	`MRCT_ASSERT_SAME(a_ignored_clean, clk, arst_n,
		out_valid && (verdict == mrct_pkg::V_IGNORED),
		(slot == 3'd0) && (packet_count == 8'd0) && !deliver,
		"ignored request carries nonzero result fields")

	`MRCT_ASSERT_SAME(a_deliver_match, clk, arst_n, out_valid,
		deliver == ((verdict == mrct_pkg::V_SINGLE) || (verdict == mrct_pkg::V_COMPLETED)),
		"deliver disagrees with verdict")

	`MRCT_ASSERT_NEXT(a_request_queued, clk, arst_n, in_valid && !in_stall, q_valid,
		"accepted request missing from queue")

endmodule

[sv/mrct_ram.sv]
// Generic single write port RAM with registered read.
module mrct_ram #(
	parameter int WIDTH = 22,
	parameter int DEPTH = 8
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/mrct_front.sv]
// Front end: configuration registers, request intake and classification.
module mrct_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mrct_pkg::ADDR_W-1:0] paddr,
	input  logic [mrct_pkg::DATA_W-1:0] pwdata,
	output logic [mrct_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [3:0]                  version,
	input  logic [7:0]                  dest_eid,
	input  logic [7:0]                  source_eid,
	input  logic [2:0]                  msg_tag,
	input  logic                        msg_owner,
	input  logic                        start_of_msg,
	input  logic                        end_of_msg,
	input  logic [mrct_pkg::SEQ_W-1:0]  seq_num,
	input  logic [mrct_pkg::LEN_W-1:0]  packet_len,
	input  logic                        q_full,
	output logic                        push,
	output mrct_pkg::cmd_t              cmd
);

	logic [7:0]                 own_eid_q;
	logic [3:0]                 hdr_ver_q;
	logic [mrct_pkg::LEN_W-1:0] full_len_q;
	logic                       wr_en;
	mrct_pkg::reg_idx_t         reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = mrct_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_eid_q  <= 8'd0;
			hdr_ver_q  <= 4'd1;
			full_len_q <= 11'd68;
		end else if (wr_en) begin
			case (reg_idx)
				mrct_pkg::REG_OWN_EID:  own_eid_q  <= pwdata[7:0];
				mrct_pkg::REG_HDR_VER:  hdr_ver_q  <= pwdata[3:0];
				mrct_pkg::REG_FULL_LEN: full_len_q <= pwdata[mrct_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			mrct_pkg::REG_OWN_EID:  prdata = {24'd0, own_eid_q};
			mrct_pkg::REG_HDR_VER:  prdata = {28'd0, hdr_ver_q};
			mrct_pkg::REG_FULL_LEN: prdata = {21'd0, full_len_q};
			default:                prdata = '0;
		endcase
	end

	assign in_stall = q_full;
	assign push     = in_valid & ~q_full;

	always_comb begin
		cmd.key      = {msg_owner, msg_tag, source_eid};
		cmd.som      = start_of_msg;
		cmd.eom      = end_of_msg;
		cmd.full_len = (packet_len == full_len_q);
		cmd.seq      = seq_num;
		if ((version != hdr_ver_q) || (dest_eid != own_eid_q)) begin
			cmd.kind = mrct_pkg::K_IGNORE;
		end else if (start_of_msg && end_of_msg) begin
			cmd.kind = mrct_pkg::K_SINGLE;
		end else begin
			cmd.kind = mrct_pkg::K_LOOKUP;
		end
	end

endmodule

[sv/mrct_queue.sv]
// Two-entry request queue between front and back.
module mrct_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mrct_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           q_valid,
	output mrct_pkg::cmd_t q_cmd
);

	mrct_pkg::cmd_t slots_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign full    = (count_q == 2'd2);
	assign q_valid = (count_q != 2'd0);
	assign q_cmd   = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[sv/mrct_back.sv]
// Back end: context table scan, verdict and result register.
module mrct_back #(
	parameter int CONTEXTS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	input  mrct_pkg::cmd_t             q_cmd,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [3:0]                 verdict,
	output logic [2:0]                 slot,
	output logic [mrct_pkg::CNT_W-1:0] packet_count,
	output logic                       deliver
);

	localparam int IDX_W = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CONTEXTS - 1);

	mrct_pkg::st_t st_q, st_d;

	mrct_pkg::cmd_t             cmd_q;
	logic [CONTEXTS-1:0]        valid_q;
	logic [IDX_W-1:0]           idx_q;
	logic                       rd_vld_s1;
	logic [IDX_W-1:0]           rd_idx_s1;
	logic                       found_q;
	logic [IDX_W-1:0]           m_idx_q;
	logic [mrct_pkg::SEQ_W-1:0] m_seq_q;
	logic [mrct_pkg::CNT_W-1:0] m_count_q;
	logic                       free_found_q;
	logic [IDX_W-1:0]           f_idx_q;

	logic                       out_valid_q;
	mrct_pkg::verdict_t         verdict_q;
	logic [2:0]                 slot_q;
	logic [mrct_pkg::CNT_W-1:0] count_q;
	logic                       deliver_q;

	logic                       out_free;
	logic                       rd_en;
	logic [$bits(mrct_pkg::entry_t)-1:0] rd_data;
	mrct_pkg::entry_t           rd_entry;
	logic                       wr_en;
	logic [IDX_W-1:0]           wr_idx;
	mrct_pkg::entry_t           wr_entry;
	logic                       set_valid;
	logic                       clr_valid;
	logic                       scan_init;
	logic                       load_out;
	mrct_pkg::verdict_t         d_verdict;
	logic [IDX_W-1:0]           d_slot_idx;
	logic                       d_use_slot;
	logic [mrct_pkg::CNT_W-1:0] d_count;
	logic                       d_deliver;
	logic [mrct_pkg::CNT_W-1:0] next_count;
	logic [mrct_pkg::SEQ_W-1:0] exp_seq;
	logic [IDX_W+2:0]           slot_ext;

	assign out_free   = ~out_valid_q | ~out_stall;
	assign rd_entry   = rd_data;
	assign next_count = (m_count_q == mrct_pkg::CNT_MAX) ? m_count_q :
		m_count_q + mrct_pkg::CNT_W'(1);
	assign exp_seq    = m_seq_q + mrct_pkg::SEQ_W'(1);

	mrct_ram #(
		.WIDTH($bits(mrct_pkg::entry_t)),
		.DEPTH(CONTEXTS)
	) u_table (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_idx),
		.wdata(wr_entry),
		.re   (rd_en),
		.raddr(idx_q),
		.rdata(rd_data)
	);

	always_comb begin
		st_d = st_q;
		case (st_q)
			mrct_pkg::ST_IDLE: begin
				if (q_valid && (q_cmd.kind == mrct_pkg::K_LOOKUP)) begin
					st_d = mrct_pkg::ST_SCAN;
				end
			end
			mrct_pkg::ST_SCAN: begin
				if (idx_q == LAST_IDX) begin
					st_d = mrct_pkg::ST_LAST;
				end
			end
			mrct_pkg::ST_LAST: st_d = mrct_pkg::ST_DECIDE;
			mrct_pkg::ST_DECIDE: begin
				if (out_free) begin
					st_d = mrct_pkg::ST_IDLE;
				end
			end
			default: st_d = mrct_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		pop        = 1'b0;
		scan_init  = 1'b0;
		rd_en      = 1'b0;
		wr_en      = 1'b0;
		wr_idx     = m_idx_q;
		wr_entry   = '{key: cmd_q.key, seq: cmd_q.seq, count: next_count};
		set_valid  = 1'b0;
		clr_valid  = 1'b0;
		load_out   = 1'b0;
		d_verdict  = mrct_pkg::V_IGNORED;
		d_use_slot = 1'b0;
		d_slot_idx = m_idx_q;
		d_count    = '0;
		d_deliver  = 1'b0;
		case (st_q)
			mrct_pkg::ST_IDLE: begin
				if (q_valid && (q_cmd.kind == mrct_pkg::K_LOOKUP)) begin
					pop       = 1'b1;
					scan_init = 1'b1;
				end else if (q_valid && out_free) begin
					pop      = 1'b1;
					load_out = 1'b1;
					if (q_cmd.kind == mrct_pkg::K_SINGLE) begin
						d_verdict = mrct_pkg::V_SINGLE;
						d_count   = mrct_pkg::CNT_W'(1);
						d_deliver = 1'b1;
					end
				end
			end
			mrct_pkg::ST_SCAN: rd_en = 1'b1;
			mrct_pkg::ST_LAST: ;
			mrct_pkg::ST_DECIDE: begin
				load_out = out_free;
				if (cmd_q.som) begin
					if (!cmd_q.full_len) begin
						d_verdict  = mrct_pkg::V_BADLEN;
						d_use_slot = found_q;
						clr_valid  = found_q;
					end else if (!found_q && !free_found_q) begin
						d_verdict = mrct_pkg::V_FULL;
					end else begin
						d_verdict  = mrct_pkg::V_STARTED;
						d_use_slot = 1'b1;
						d_slot_idx = found_q ? m_idx_q : f_idx_q;
						d_count    = mrct_pkg::CNT_W'(1);
						wr_idx     = d_slot_idx;
						wr_entry   = '{key: cmd_q.key, seq: cmd_q.seq,
							count: mrct_pkg::CNT_W'(1)};
						wr_en      = 1'b1;
						set_valid  = 1'b1;
					end
				end else if (!found_q) begin
					d_verdict = mrct_pkg::V_ORPHAN;
				end else if (!cmd_q.full_len && !cmd_q.eom) begin
					d_verdict  = mrct_pkg::V_BADLEN;
					d_use_slot = 1'b1;
					clr_valid  = 1'b1;
				end else if (cmd_q.seq != exp_seq) begin
					d_verdict  = mrct_pkg::V_BADSEQ;
					d_use_slot = 1'b1;
					clr_valid  = 1'b1;
				end else if (cmd_q.eom) begin
					d_verdict  = mrct_pkg::V_COMPLETED;
					d_use_slot = 1'b1;
					d_count    = next_count;
					d_deliver  = 1'b1;
					clr_valid  = 1'b1;
				end else begin
					d_verdict  = mrct_pkg::V_APPENDED;
					d_use_slot = 1'b1;
					d_count    = next_count;
					wr_en      = 1'b1;
				end
				if (!out_free) begin
					wr_en     = 1'b0;
					set_valid = 1'b0;
					clr_valid = 1'b0;
				end
			end
			default: ;
		endcase
		slot_ext = d_use_slot ? (IDX_W+3)'(d_slot_idx) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= mrct_pkg::ST_IDLE;
			valid_q     <= '0;
			idx_q       <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q      <= st_d;
			rd_vld_s1 <= rd_en;
			if (scan_init) begin
				idx_q <= '0;
			end else if (rd_en && (idx_q != LAST_IDX)) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (set_valid) begin
				valid_q[wr_idx] <= 1'b1;
			end
			if (clr_valid) begin
				valid_q[m_idx_q] <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q;
		if (scan_init) begin
			cmd_q        <= q_cmd;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
		end else if (rd_vld_s1) begin
			if (valid_q[rd_idx_s1] && (rd_entry.key == cmd_q.key) && !found_q) begin
				found_q   <= 1'b1;
				m_idx_q   <= rd_idx_s1;
				m_seq_q   <= rd_entry.seq;
				m_count_q <= rd_entry.count;
			end
			if (!valid_q[rd_idx_s1] && !free_found_q) begin
				free_found_q <= 1'b1;
				f_idx_q      <= rd_idx_s1;
			end
		end
		if (load_out) begin
			verdict_q <= d_verdict;
			slot_q    <= slot_ext[2:0];
			count_q   <= d_count;
			deliver_q <= d_deliver;
		end
	end

	assign out_valid    = out_valid_q;
	assign verdict      = verdict_q;
	assign slot         = slot_q;
	assign packet_count = count_q;
	assign deliver      = deliver_q;

endmodule
